>>> rtl/core/signed_integer_to_any_base_text_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to text block.
// Shared checks are written through these macros so every use looks the same.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_ANY_BASE_TEXT_TOP_DEFINES_SVH
`define SIGNED_INTEGER_TO_ANY_BASE_TEXT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the block clock.
`define SITXT_ASSERT_SAME(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("sitxt: same-cycle check failed");

// Next-cycle implication, sampled on the block clock.
`define SITXT_ASSERT_NEXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("sitxt: next-cycle check failed");

`endif

>>> rtl/core/sitxt_pkg.sv
// ----------------------------------------------------------------------------
// sitxt_pkg
// Constants, register codes and the shared divide step of the integer to
// text block.
// ----------------------------------------------------------------------------
package sitxt_pkg;

   localparam int SYM_COUNT   = 16;   // alphabet entries
   localparam int SYM_IDX_W   = 4;
   localparam int BYTE_W      = 8;
   localparam int BASE_W      = 5;    // base runs up to 16
   localparam int VALUE_W     = 32;
   localparam int DIGIT_SLOTS = 32;
   localparam int SLOT_W      = 5;
   localparam int CNT_W       = 6;    // digit count, 0 to 32
   localparam int STEP_W      = 2;    // byte position inside the value
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [BYTE_W-1:0] SIGN_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] SIGN_PLUS  = 8'h2B;

   localparam logic [CSR_DATA_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

   // Register index, taken from address bit 3.
   localparam logic REG_SYMBOLS_LOW  = 1'b0;
   localparam logic REG_SYMBOLS_HIGH = 1'b1;

   // One byte of long division by a base of 2 to 16: eight restoring steps
   // on a five-bit partial remainder. Returns {remainder, quotient byte}.
   function automatic logic [SYM_IDX_W+BYTE_W-1:0] div_byte(
      input logic [SYM_IDX_W-1:0] rem_i,
      input logic [BYTE_W-1:0]    num_i,
      input logic [BASE_W-1:0]    base_i
   );
      logic [BASE_W-1:0] r;
      logic [BYTE_W-1:0] q;
      r = {1'b0, rem_i};
      q = '0;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         r = {r[SYM_IDX_W-1:0], num_i[k]};
         if (r >= base_i) begin
            r    = r - base_i;
            q[k] = 1'b1;
         end
      end
      return {r[SYM_IDX_W-1:0], q};
   endfunction

endpackage

>>> rtl/core/signed_integer_to_any_base_text_top.sv
// Flow: the request is accepted, the alphabet is checked entry by entry, the divider
// works through the magnitude one byte at a time for each digit, then one output word
// per cycle while the output is not stalled, sign first if negative. Zero and a bad
// alphabet skip the divider.
// One item is in work at a time; the next is taken once the last word is queued.
// Reset is synchronous: control clears, the alphabet returns to "0123456789".
// ----------------------------------------------------------------------------
// signed_integer_to_any_base_text_top
// Writes a signed 32-bit value as text in the base given by a configured
// alphabet, most significant symbol first, one byte per output word.
// ----------------------------------------------------------------------------
`include "signed_integer_to_any_base_text_top_defines.svh"

module signed_integer_to_any_base_text_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sitxt_pkg::VALUE_W-1:0]   req_value,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sitxt_pkg::BYTE_W-1:0]           rsp_symbol,
   output logic                                   rsp_last,
   output logic                                   rsp_bad_alphabet,
   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [sitxt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sitxt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sitxt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT,
      ST_REJECT
   } state_type;

   state_type                            state_ff, state_in;
   logic [sitxt_pkg::CSR_DATA_W-1:0]     sym_low_ff, sym_low_in;
   logic [sitxt_pkg::CSR_DATA_W-1:0]     sym_high_ff, sym_high_in;
   logic                                 neg_ff, neg_in;
   logic [sitxt_pkg::VALUE_W-1:0]        mag_ff, mag_in;
   logic [sitxt_pkg::SYM_IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                                 bad_ff, bad_in;
   logic [sitxt_pkg::SYM_IDX_W-1:0]      rem_ff, rem_in;
   logic [sitxt_pkg::STEP_W-1:0]         bstep_ff, bstep_in;
   logic [sitxt_pkg::CNT_W-1:0]          nd_ff, nd_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [sitxt_pkg::BYTE_W-1:0]         rsp_symbol_ff, rsp_symbol_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic                                 rsp_bad_ff, rsp_bad_in;

   logic [sitxt_pkg::SYM_IDX_W-1:0]      digits_ff [sitxt_pkg::DIGIT_SLOTS];
   logic                                 dig_we;
   logic [sitxt_pkg::SLOT_W-1:0]         dig_waddr;
   logic [sitxt_pkg::SYM_IDX_W-1:0]      dig_wdata;
   logic [sitxt_pkg::SLOT_W-1:0]         dig_raddr;
   logic [sitxt_pkg::SYM_IDX_W-1:0]      dig_rdata;

   logic [sitxt_pkg::BYTE_W-1:0]         alpha [sitxt_pkg::SYM_COUNT];
   logic [sitxt_pkg::BASE_W-1:0]         base;
   logic [sitxt_pkg::BYTE_W-1:0]         cur_sym;
   logic                                 dup_hit;
   logic                                 sym_bad;
   logic [sitxt_pkg::SYM_IDX_W+sitxt_pkg::BYTE_W-1:0] div_res;
   logic [sitxt_pkg::VALUE_W-1:0]        mag_next;
   logic                                 out_free;
   logic                                 csr_wr;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == sitxt_pkg::REG_SYMBOLS_HIGH) ? sym_high_ff
                                                                     : sym_low_ff;

   always_comb begin
      sym_low_in  = sym_low_ff;
      sym_high_in = sym_high_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3])
            sitxt_pkg::REG_SYMBOLS_LOW:  sym_low_in  = csr_pwdata;
            sitxt_pkg::REG_SYMBOLS_HIGH: sym_high_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Alphabet view: length is the index of the first zero byte.
   // ------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < sitxt_pkg::SYM_COUNT / 2; i++) begin
         alpha[i]                            = sym_low_ff[i*8 +: 8];
         alpha[i + sitxt_pkg::SYM_COUNT / 2] = sym_high_ff[i*8 +: 8];
      end
   end

   always_comb begin
      base = sitxt_pkg::BASE_W'(sitxt_pkg::SYM_COUNT);
      for (int i = sitxt_pkg::SYM_COUNT - 1; i >= 0; i--) begin
         if (alpha[i] == '0) begin
            base = sitxt_pkg::BASE_W'(i);
         end
      end
   end

   // Shared compare unit: one alphabet entry against all later ones per cycle.
   assign cur_sym = alpha[chk_idx_ff];

   always_comb begin
      dup_hit = 1'b0;
      for (int j = 0; j < sitxt_pkg::SYM_COUNT; j++) begin
         if ((sitxt_pkg::BASE_W'(j) > {1'b0, chk_idx_ff}) &&
             (sitxt_pkg::BASE_W'(j) < base) && (alpha[j] == cur_sym)) begin
            dup_hit = 1'b1;
         end
      end
   end

   assign sym_bad = ({1'b0, chk_idx_ff} < base) &&
                    ((cur_sym == sitxt_pkg::SIGN_PLUS) ||
                     (cur_sym == sitxt_pkg::SIGN_MINUS) || dup_hit);

   // ------------------------------------------------------------------
   // Shared divider: one byte of the magnitude per cycle, high byte first.
   // ------------------------------------------------------------------
   assign div_res = sitxt_pkg::div_byte(rem_ff, mag_ff[bstep_ff*8 +: 8], base);

   always_comb begin
      mag_next                 = mag_ff;
      mag_next[bstep_ff*8 +: 8] = div_res[sitxt_pkg::BYTE_W-1:0];
   end

   // Digit store, written least significant first and read back in reverse.
   assign dig_raddr = sitxt_pkg::SLOT_W'(nd_ff - 1'b1);
   assign dig_rdata = digits_ff[dig_raddr];

   always_ff @(posedge clock) begin
      if (dig_we) begin
         digits_ff[dig_waddr] <= dig_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      chk_idx_in    = chk_idx_ff;
      bad_in        = bad_ff;
      rem_in        = rem_ff;
      bstep_in      = bstep_ff;
      nd_in         = nd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_bad_in    = rsp_bad_ff;
      dig_we        = 1'b0;
      dig_waddr     = nd_ff[sitxt_pkg::SLOT_W-1:0];
      dig_wdata     = rem_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in     = req_value[sitxt_pkg::VALUE_W-1];
               // The most negative value negates to itself, which is 2^31 unsigned.
               mag_in     = req_value[sitxt_pkg::VALUE_W-1] ? (~req_value + 1'b1)
                                                            : req_value;
               chk_idx_in = '0;
               bad_in     = (base < sitxt_pkg::BASE_W'(2));
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            bad_in = bad_ff || sym_bad;
            if (chk_idx_ff == sitxt_pkg::SYM_IDX_W'(sitxt_pkg::SYM_COUNT - 1)) begin
               nd_in = '0;
               if (bad_in) begin
                  state_in = ST_REJECT;
               end else if (mag_ff == '0) begin
                  // Zero is written as alphabet entry 0.
                  dig_we    = 1'b1;
                  dig_waddr = '0;
                  dig_wdata = '0;
                  nd_in     = sitxt_pkg::CNT_W'(1);
                  state_in  = neg_ff ? ST_SIGN : ST_EMIT;
               end else begin
                  rem_in   = '0;
                  bstep_in = '1;
                  state_in = ST_DIVIDE;
               end
            end else begin
               chk_idx_in = chk_idx_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            mag_in = mag_next;
            if (bstep_ff == '0) begin
               dig_we    = 1'b1;
               dig_wdata = div_res[sitxt_pkg::SYM_IDX_W+sitxt_pkg::BYTE_W-1:sitxt_pkg::BYTE_W];
               nd_in     = nd_ff + 1'b1;
               rem_in    = '0;
               bstep_in  = '1;
               if (mag_next == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end else begin
               rem_in   = div_res[sitxt_pkg::SYM_IDX_W+sitxt_pkg::BYTE_W-1:sitxt_pkg::BYTE_W];
               bstep_in = bstep_ff - 1'b1;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = sitxt_pkg::SIGN_MINUS;
               rsp_last_in   = 1'b0;
               rsp_bad_in    = 1'b0;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = alpha[dig_rdata];
               rsp_last_in   = (nd_ff == sitxt_pkg::CNT_W'(1));
               rsp_bad_in    = 1'b0;
               nd_in         = nd_ff - 1'b1;
               if (nd_ff == sitxt_pkg::CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = '0;
               rsp_last_in   = 1'b1;
               rsp_bad_in    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sym_low_ff   <= sitxt_pkg::SYMBOLS_LOW_RESET;
         sym_high_ff  <= sitxt_pkg::SYMBOLS_HIGH_RESET;
         rsp_valid_ff <= 1'b0;
         nd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         sym_low_ff   <= sym_low_in;
         sym_high_ff  <= sym_high_in;
         rsp_valid_ff <= rsp_valid_in;
         nd_ff        <= nd_in;
      end
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      chk_idx_ff    <= chk_idx_in;
      bad_ff        <= bad_in;
      rem_ff        <= rem_in;
      bstep_ff      <= bstep_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_bad_alphabet = rsp_bad_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `SITXT_ASSERT_SAME(a_bad_word_form, reset, rsp_valid && rsp_bad_alphabet, rsp_last && (rsp_symbol == '0))
   `SITXT_ASSERT_SAME(a_digit_count, reset, 1'b1, nd_ff <= sitxt_pkg::CNT_W'(sitxt_pkg::DIGIT_SLOTS))
   `SITXT_ASSERT_SAME(a_rem_below_base, reset, state_ff == ST_DIVIDE, {1'b0, rem_ff} < base)
   `SITXT_ASSERT_NEXT(a_reject_word, reset, (state_ff == ST_REJECT) && out_free, rsp_valid && rsp_bad_alphabet)

endmodule
